/* rtl/qchd_pkg.sv */
// Package for the quantized color histogram difference unit.
// Holds command and register codes, queue item and state types, and the
// reciprocal constants for the channel divide. No dependencies.
package qchd_pkg;

    localparam int CHAN_W   = 8;
    localparam int BUCKET_W = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;
    localparam int DIV_ENTRIES = 256;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam logic [1:0] CMD_INS_A = 2'd0;
    localparam logic [1:0] CMD_INS_B = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic REG_FUDGE    = 1'b0;
    localparam logic REG_ADDITIVE = 1'b1;

    localparam logic [CHAN_W-1:0] FUDGE_RESET    = 8'd10;
    localparam logic              ADDITIVE_RESET = 1'b1;

    typedef enum logic [1:0] {
        OP_INS_A,
        OP_INS_B,
        OP_QUERY,
        OP_CLEAR
    } qchd_op_t;

    typedef struct packed {
        qchd_op_t              op;
        logic                  in_range;
        logic [BUCKET_W-1:0]   addr;
        logic [BUCKET_W-1:0]   bucket;
    } qchd_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } qchd_state_t;

endpackage

/* rtl/qchd_pixel_if.sv */
// Input channel of the histogram unit: command and pixel or bucket.
// Uses qchd_pkg for field widths.
interface qchd_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       cmd;
    logic [qchd_pkg::CHAN_W-1:0]      red;
    logic [qchd_pkg::CHAN_W-1:0]      green;
    logic [qchd_pkg::CHAN_W-1:0]      blue;
    logic [qchd_pkg::BUCKET_W-1:0]    query_bucket;

    modport source (output valid, cmd, red, green, blue, query_bucket, input ready);
    modport sink   (input valid, cmd, red, green, blue, query_bucket, output ready);
endinterface

/* rtl/qchd_result_if.sv */
// Result channel of the histogram unit: queried bucket, both counts, flag.
// Uses qchd_pkg for the bucket width.
interface qchd_result_if #(
    parameter int COUNT_BITS = 21
);
    logic                             valid;
    logic                             ready;
    logic [qchd_pkg::BUCKET_W-1:0]    result_bucket;
    logic [COUNT_BITS-1:0]            pixels_in_a;
    logic [COUNT_BITS-1:0]            pixels_in_b;
    logic                             discrepancy;

    modport source (output valid, result_bucket, pixels_in_a, pixels_in_b, discrepancy,
                    input ready);
    modport sink   (input valid, result_bucket, pixels_in_a, pixels_in_b, discrepancy,
                    output ready);
endinterface

/* rtl/qchd_cfg_if.sv */
// Configuration write channel of the histogram unit.
// Uses qchd_pkg for the data width.
interface qchd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic                           index;
    logic [qchd_pkg::CHAN_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/qchd_front.sv */
// Front end: accepts items, divides channels into levels, forms bucket address.
// Uses qchd_pkg and qchd_pixel_if; feeds the item queue.
module qchd_front #(
    parameter int LEVELS_PER_CHANNEL = 32
) (
    qchd_pixel_if.sink               pixel,
    input  logic [qchd_pkg::CHAN_W-1:0] bucket_div,
    input  logic                     clearing,
    input  logic                     q_ready,
    output logic                     q_valid,
    output qchd_pkg::qchd_item_t     q_item
);

    localparam int BUCKETS = LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL;
    localparam int AW      = $clog2(BUCKETS);
    localparam int RW      = qchd_pkg::RECIP_W;
    localparam int RS      = qchd_pkg::RECIP_SHIFT;
    localparam int PW      = qchd_pkg::CHAN_W + qchd_pkg::RECIP_W;
    localparam logic [qchd_pkg::CHAN_W:0] LEV = (qchd_pkg::CHAN_W + 1)'(LEVELS_PER_CHANNEL);
    localparam logic [AW-1:0] L1 = AW'(LEVELS_PER_CHANNEL);
    localparam logic [AW-1:0] L2 = AW'(LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL);

    logic [qchd_pkg::DIV_ENTRIES-1:0][RW-1:0] recip_tab;
    logic [RW-1:0]               recip;
    logic [PW-1:0]               prod_r;
    logic [PW-1:0]               prod_g;
    logic [PW-1:0]               prod_b;
    logic [qchd_pkg::CHAN_W-1:0] lev_r;
    logic [qchd_pkg::CHAN_W-1:0] lev_g;
    logic [qchd_pkg::CHAN_W-1:0] lev_b;
    logic                        is_insert;
    logic                        in_range;
    logic [AW-1:0]               addr;
    qchd_pkg::qchd_op_t          op;

    for (genvar d = 0; d < qchd_pkg::DIV_ENTRIES; d++)
    begin : g_recip
        localparam int DEN = (d == 0) ? 1 : d;
        assign recip_tab[d] = RW'(((1 << RS) + DEN - 1) / DEN);
    end

    assign recip     = recip_tab[bucket_div];
    assign prod_r    = PW'(pixel.red & qchd_pkg::CHAN_MAX) * PW'(recip);
    assign prod_g    = PW'(pixel.green & qchd_pkg::CHAN_MAX) * PW'(recip);
    assign prod_b    = PW'(pixel.blue & qchd_pkg::CHAN_MAX) * PW'(recip);
    assign is_insert = (pixel.cmd == qchd_pkg::CMD_INS_A) || (pixel.cmd == qchd_pkg::CMD_INS_B);

    always_comb
    begin
        if (is_insert)
        begin
            lev_r = prod_r[RS +: qchd_pkg::CHAN_W];
            lev_g = prod_g[RS +: qchd_pkg::CHAN_W];
            lev_b = prod_b[RS +: qchd_pkg::CHAN_W];
        end
        else
        begin
            lev_r = pixel.query_bucket[7:0];
            lev_g = pixel.query_bucket[15:8];
            lev_b = pixel.query_bucket[23:16];
        end
    end

    assign in_range = ({1'b0, lev_r} < LEV) && ({1'b0, lev_g} < LEV) && ({1'b0, lev_b} < LEV);
    assign addr     = AW'(lev_r) + AW'(lev_g) * L1 + AW'(lev_b) * L2;

    always_comb
    begin
        case (pixel.cmd)
            qchd_pkg::CMD_INS_A: op = qchd_pkg::OP_INS_A;
            qchd_pkg::CMD_INS_B: op = qchd_pkg::OP_INS_B;
            qchd_pkg::CMD_QUERY: op = qchd_pkg::OP_QUERY;
            qchd_pkg::CMD_CLEAR: op = qchd_pkg::OP_CLEAR;
            default:             op = qchd_pkg::OP_QUERY;
        endcase
    end

    assign pixel.ready     = q_ready && !clearing;
    assign q_valid         = pixel.valid && !clearing && !(is_insert && !in_range);
    assign q_item.op       = op;
    assign q_item.in_range = in_range;
    assign q_item.addr     = qchd_pkg::BUCKET_W'(addr);
    assign q_item.bucket   = pixel.query_bucket;

endmodule

/* rtl/qchd_fifo.sv */
// Short item queue between front end and store access.
// Uses qchd_pkg for the item type and depth.
module qchd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qchd_pkg::qchd_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qchd_pkg::qchd_item_t out_item
);

    localparam int PW = $clog2(qchd_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(qchd_pkg::QUEUE_DEPTH + 1);

    qchd_pkg::qchd_item_t slot_reg [qchd_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(qchd_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/qchd_back.sv */
// Back end: owns both count stores, runs clears, inserts and queries.
// Uses qchd_pkg and qchd_result_if; takes items from the queue.
module qchd_back #(
    parameter int LEVELS_PER_CHANNEL = 32,
    parameter int COUNT_BITS         = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  qchd_pkg::qchd_item_t q_item,
    input  logic                 one_sided,
    output logic                 clearing,
    qchd_result_if.source        result
);

    localparam int BUCKETS = LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL * LEVELS_PER_CHANNEL;
    localparam int AW      = $clog2(BUCKETS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUCKETS - 1);

    logic [COUNT_BITS-1:0] mem_a [BUCKETS];
    logic [COUNT_BITS-1:0] mem_b [BUCKETS];

    qchd_pkg::qchd_state_t state_reg;
    qchd_pkg::qchd_state_t state_next;
    logic [AW-1:0]         clr_addr_reg;
    logic [AW-1:0]         clr_addr_next;
    qchd_pkg::qchd_op_t    cur_op_reg;
    logic [AW-1:0]         cur_addr_reg;
    logic [qchd_pkg::BUCKET_W-1:0] cur_bucket_reg;
    logic [COUNT_BITS-1:0] rd_a_reg;
    logic [COUNT_BITS-1:0] rd_b_reg;
    logic                  out_valid_reg;
    logic [qchd_pkg::BUCKET_W-1:0] out_bucket_reg;
    logic [COUNT_BITS-1:0] out_a_reg;
    logic [COUNT_BITS-1:0] out_b_reg;
    logic                  out_flag_reg;

    logic                  slot_free;
    logic                  take;
    logic                  load_miss;
    logic                  load_hit;
    logic                  we_a;
    logic                  we_b;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] wd_a;
    logic [COUNT_BITS-1:0] wd_b;
    logic                  hit_flag;

    assign slot_free = !out_valid_reg || result.ready;
    assign take      = q_valid && q_ready;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            qchd_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = qchd_pkg::ST_IDLE;
                end
            end
            qchd_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    if (q_item.op == qchd_pkg::OP_CLEAR)
                    begin
                        state_next    = qchd_pkg::ST_CLEAR;
                        clr_addr_next = '0;
                    end
                    else if (q_item.in_range)
                    begin
                        state_next = qchd_pkg::ST_ACCESS;
                    end
                end
            end
            qchd_pkg::ST_ACCESS:
            begin
                state_next = qchd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = qchd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_ready   = 1'b0;
        load_miss = 1'b0;
        load_hit  = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        wr_addr   = cur_addr_reg;
        wd_a      = rd_a_reg + COUNT_BITS'(1);
        wd_b      = rd_b_reg + COUNT_BITS'(1);
        clearing  = 1'b0;
        case (state_reg)
            qchd_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
                we_a     = 1'b1;
                we_b     = 1'b1;
                wr_addr  = clr_addr_reg;
                wd_a     = '0;
                wd_b     = '0;
            end
            qchd_pkg::ST_IDLE:
            begin
                q_ready   = (q_item.op != qchd_pkg::OP_QUERY) || slot_free;
                load_miss = take && (q_item.op == qchd_pkg::OP_QUERY) && !q_item.in_range;
            end
            qchd_pkg::ST_ACCESS:
            begin
                load_hit = (cur_op_reg == qchd_pkg::OP_QUERY);
                we_a     = (cur_op_reg == qchd_pkg::OP_INS_A) && (rd_a_reg != '1);
                we_b     = (cur_op_reg == qchd_pkg::OP_INS_B) && (rd_b_reg != '1);
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    assign hit_flag = (rd_a_reg != rd_b_reg)
                   && !(one_sided && (rd_a_reg != '0) && (rd_b_reg != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qchd_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            if (load_miss || load_hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_op_reg     <= q_item.op;
            cur_addr_reg   <= q_item.addr[AW-1:0];
            cur_bucket_reg <= q_item.bucket;
        end
        if (load_miss)
        begin
            out_bucket_reg <= q_item.bucket;
            out_a_reg      <= '0;
            out_b_reg      <= '0;
            out_flag_reg   <= 1'b0;
        end
        else if (load_hit)
        begin
            out_bucket_reg <= cur_bucket_reg;
            out_a_reg      <= rd_a_reg;
            out_b_reg      <= rd_b_reg;
            out_flag_reg   <= hit_flag;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem_a[q_item.addr[AW-1:0]];
        if (we_a)
        begin
            mem_a[wr_addr] <= wd_a;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_b_reg <= mem_b[q_item.addr[AW-1:0]];
        if (we_b)
        begin
            mem_b[wr_addr] <= wd_b;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.result_bucket = out_bucket_reg;
    assign result.pixels_in_a   = out_a_reg;
    assign result.pixels_in_b   = out_b_reg;
    assign result.discrepancy   = out_flag_reg;

endmodule

/* rtl/quantized_color_histogram_diff_unit.sv */
// Quantized RGB color histogram difference unit, top level.
// Uses qchd_pkg, the three channel interfaces, qchd_front, qchd_fifo, qchd_back.
//
// Channels: pixel carries cmd (insert A, insert B, query, clear) with the
// pixel channels or a packed query bucket; result carries one item per query
// with both counts and the discrepancy flag; cfg writes the bucket divisor
// (index 0) and the one-sided flag mode (index 1) and is always ready.
// Result path: an in-range query taken from the queue passes the store read
// registers, then the output register; one outside the store loads the output
// register directly. Pacing: an in-range insert or query holds the back end in
// its access state for the read-modify-write on the count stores before the
// next item is taken; an insert outside the store is dropped; up to 4 items
// buffer in the queue. Clear: a clear item sweeps both stores, one entry per
// cycle, LEVELS_PER_CHANNEL^3 entries; pixel.ready is low meanwhile.
// Reset: the same sweep runs right after rst_n releases, registers return to
// a divisor of 10 and one-sided mode on.
// Stall: a result holds in its output register while result.ready is low;
// inserts keep going, and the next query waits for the register to free.
module quantized_color_histogram_diff_unit #(
    parameter int LEVELS_PER_CHANNEL = 32,
    parameter int COUNT_BITS         = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    qchd_pixel_if.sink    pixel,
    qchd_result_if.source result,
    qchd_cfg_if.sink      cfg
);

    logic [qchd_pkg::CHAN_W-1:0] fudge_reg;
    logic                        additive_reg;
    logic                        clearing;
    logic                        fq_valid;
    logic                        fq_ready;
    qchd_pkg::qchd_item_t        fq_item;
    logic                        bq_valid;
    logic                        bq_ready;
    qchd_pkg::qchd_item_t        bq_item;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fudge_reg    <= qchd_pkg::FUDGE_RESET;
            additive_reg <= qchd_pkg::ADDITIVE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                qchd_pkg::REG_FUDGE:    fudge_reg    <= cfg.data;
                qchd_pkg::REG_ADDITIVE: additive_reg <= cfg.data[0];
                default:                fudge_reg    <= fudge_reg;
            endcase
        end
    end

    qchd_front #(
        .LEVELS_PER_CHANNEL (LEVELS_PER_CHANNEL)
    ) u_front (
        .pixel        (pixel),
        .bucket_div   (fudge_reg),
        .clearing     (clearing),
        .q_ready      (fq_ready),
        .q_valid      (fq_valid),
        .q_item       (fq_item)
    );

    qchd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_item  (bq_item)
    );

    qchd_back #(
        .LEVELS_PER_CHANNEL (LEVELS_PER_CHANNEL),
        .COUNT_BITS         (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (bq_valid),
        .q_ready       (bq_ready),
        .q_item        (bq_item),
        .one_sided     (additive_reg),
        .clearing      (clearing),
        .result        (result)
    );

endmodule
